// ===== hdl/cma_pkg.sv =====
// Package for the centered moving average block: fixed field widths,
// register reset value and sizes shared by the interfaces and modules.
// No dependencies.
package cma_pkg;

  localparam int SAMPLE_W = 16;          // Q1.15 sample width
  localparam int WW_W = 6;               // window_width register width
  localparam int QUOT_W = 16;            // magnitude of a rounded mean
  localparam int QUEUE_DEPTH = 4;        // command queue between front and back

  localparam logic [WW_W-1:0] WW_RESET = 6'd3;
  localparam logic [WW_W-1:0] MIN_WINDOW = 6'd3;

endpackage

// ===== hdl/cma_in_if.sv =====
// Input sample channel: valid/ready handshake with sample and last flag.
// Depends on cma_pkg.
interface cma_in_if;

  logic valid;
  logic ready;
  logic signed [cma_pkg::SAMPLE_W-1:0] sample_in;
  logic is_last;

  modport source (output valid, output sample_in, output is_last, input ready);
  modport sink (input valid, input sample_in, input is_last, output ready);

endinterface

// ===== hdl/cma_out_if.sv =====
// Result channel: valid/ready handshake with filtered sample and end flag.
// Depends on cma_pkg.
interface cma_out_if;

  logic valid;
  logic ready;
  logic signed [cma_pkg::SAMPLE_W-1:0] sample_out;
  logic end_of_record;

  modport source (output valid, output sample_out, output end_of_record, input ready);
  modport sink (input valid, input sample_out, input end_of_record, output ready);

endinterface

// ===== hdl/centered_moving_average.sv =====
// Top level of the centered moving average filter: window register, front,
// command queue and back. Depends on cma_pkg, cma_in_if, cma_out_if,
// cma_front, cma_queue and cma_back.
//
//   channel      | direction | payload                          | transaction
//   -------------+-----------+----------------------------------+----------------------
//   sample_chan  | in        | sample_in (s16), is_last         | valid & ready at clk
//   result_chan  | out       | sample_out (s16), end_of_record  | valid & ready at clk
//   cfg          | in        | cfg_wdata = window_width (u6)    | cfg_wen at clk
//
// The back end sends a pass-through sample out in PASS; any other sample
// goes through WRITE and SUM, then EMIT_LINE to release a delayed sample or
// DIV, the radix-2 divider, and EMIT_MEAN to produce an average. A record
// end adds FLUSH_RD and FLUSH_OUT per held sample flushed out of the delay
// line. The front accepts while the 4-entry command queue has room, so input
// and output stall independently. Reset needs no clearing pass: only delay
// line slots written in the current record are ever read.
module centered_moving_average #(
  parameter int MAX_WINDOW = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [cma_pkg::WW_W-1:0] cfg_wdata,
  cma_in_if.sink                   sample_chan,
  cma_out_if.source                result_chan
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);

  // One command per accepted sample, as classified by the front.
  typedef struct packed {
    logic signed [cma_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
    logic                                bypass;     // window inactive
    logic [PTR_W-1:0]                    wp;         // delay line slot
    logic                                sub_old;    // window full: drop oldest
    logic                                emit_now;   // a delayed sample is due
    logic                                emit_mean;  // due sample has full context
    logic [PTR_W-1:0]                    first;      // flush start distance
  } cmd_t;

  logic [cma_pkg::WW_W-1:0] window_width;
  logic                     push;
  logic                     full;
  logic                     pop;
  logic                     avail;
  cmd_t                     cmd_in;
  cmd_t                     cmd_head;

  // Hold the window length; a write also clears the record state downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= cma_pkg::WW_RESET;
    end else if (cfg_wen) begin
      window_width <= cfg_wdata;
    end
  end

  // Classify each sample and advance the record position.
  cma_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .cmd_t      (cmd_t)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_wen),
    .window_width (window_width),
    .sample_chan  (sample_chan),
    .push         (push),
    .cmd          (cmd_in),
    .full         (full)
  );

  // Buffer commands so the front keeps taking samples while results stall.
  cma_queue #(
    .DEPTH  (cma_pkg::QUEUE_DEPTH),
    .item_t (cmd_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (pop),
    .pop_data  (cmd_head),
    .avail     (avail)
  );

  // Execute commands: delay line, running sum, divide and flush.
  cma_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .cmd_t      (cmd_t)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_wen),
    .window_width (window_width),
    .avail        (avail),
    .head         (cmd_head),
    .pop          (pop),
    .result_chan  (result_chan)
  );

endmodule

// ===== hdl/cma_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/cma_queue.sv =====
// Short command queue that decouples the front from the back.
// Item type is passed in from the top level; no package dependency.
module cma_queue #(
  parameter int  DEPTH = 4,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  avail
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [ADDR_W-1:0]  head;
  logic [ADDR_W-1:0]  tail;
  logic [COUNT_W-1:0] count;

  assign full = (count == COUNT_W'(DEPTH));
  assign avail = (count != '0);
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == ADDR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/cma_front.sv =====
// Front end: accept samples, track record position and classify each one
// into a command for the back end. Depends on cma_pkg and cma_in_if.
module cma_front #(
  parameter int  MAX_WINDOW = 63,
  parameter type cmd_t = logic
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [cma_pkg::WW_W-1:0]   window_width,
  cma_in_if.sink                     sample_chan,
  output logic                       push,
  output cmd_t                       cmd,
  input  logic                       full
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SEEN_CAP = 2 * MAX_WINDOW + 1;
  localparam int SEEN_W = $clog2(SEEN_CAP + 1);
  localparam int CMP_W = (SEEN_W > cma_pkg::WW_W) ? SEEN_W : cma_pkg::WW_W;

  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  write_pointer_next;
  logic [SEEN_W-1:0] samples_seen;
  logic [SEEN_W-1:0] samples_seen_next;
  logic              active;
  logic [CMP_W-1:0]  k_c;
  logic [CMP_W-1:0]  w_c;
  logic [CMP_W-1:0]  h_c;

  always_comb begin
    active = (window_width >= cma_pkg::MIN_WINDOW) && window_width[0]
             && (int'(window_width) <= MAX_WINDOW);
    k_c = CMP_W'(samples_seen);
    w_c = CMP_W'(window_width);
    h_c = CMP_W'(window_width >> 1);

    sample_chan.ready = !full;
    push = sample_chan.valid && !full;

    cmd.sample = sample_chan.sample_in;
    cmd.last = sample_chan.is_last;
    cmd.bypass = !active;
    cmd.wp = write_pointer;
    cmd.sub_old = (k_c >= w_c);
    cmd.emit_now = (k_c >= h_c);
    cmd.emit_mean = (k_c >= w_c - CMP_W'(1));
    // Flush count: held samples after this one's own output, minus one.
    cmd.first = PTR_W'((k_c >= h_c) ? h_c - CMP_W'(1) : k_c);

    write_pointer_next = write_pointer;
    samples_seen_next = samples_seen;
    if (push && active) begin
      if (sample_chan.is_last) begin
        write_pointer_next = '0;
        samples_seen_next = '0;
      end else begin
        write_pointer_next = (write_pointer == PTR_W'(DEPTH - 1)) ? '0
                             : write_pointer + 1'b1;
        samples_seen_next = (samples_seen == SEEN_W'(SEEN_CAP)) ? samples_seen
                            : samples_seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      write_pointer <= '0;
      samples_seen <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      samples_seen <= samples_seen_next;
    end
  end

endmodule

// ===== hdl/cma_back.sv =====
// Back end: delay line, running sum, serial divider and flush sequencer.
// Depends on cma_pkg, cma_out_if and cma_ram.
module cma_back #(
  parameter int  MAX_WINDOW = 63,
  parameter type cmd_t = logic
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [cma_pkg::WW_W-1:0]   window_width,
  input  logic                       avail,
  input  cmd_t                       head,
  output logic                       pop,
  cma_out_if.source                  result_chan
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SW = cma_pkg::SAMPLE_W;
  localparam int SUM_W = SW + PTR_W;
  localparam int QW = cma_pkg::QUOT_W;
  localparam int WW = cma_pkg::WW_W;
  localparam int CNT_W = $clog2(QW);

  typedef enum logic [3:0] {
    IDLE, PASS, WRITE, SUM, EMIT_LINE, DIV, EMIT_MEAN, FLUSH_RD, FLUSH_OUT
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  num;
  logic [PTR_W-1:0]  fcnt;
  logic [WW-1:0]     rem;
  logic [QW-1:0]     dq;
  logic [CNT_W-1:0]  dcnt;
  logic              neg;
  logic [WW:0]       trial;
  logic              fits;
  logic [SW-1:0]     mean;
  logic              out_valid;
  logic [SW-1:0]     out_sample;
  logic              out_eor;
  logic              out_free;
  logic              out_load;
  logic [PTR_W-1:0]  w_p;
  logic [PTR_W-1:0]  h_p;
  logic              ram_we;
  logic              re_a;
  logic              re_b;
  logic [PTR_W-1:0]  raddr_a;
  logic [PTR_W-1:0]  raddr_b;
  logic [SW-1:0]     rdata_a;
  logic [SW-1:0]     rdata_b;

  function automatic logic [PTR_W-1:0] back_idx(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] d);
    logic [PTR_W:0] diff;
    diff = {1'b0, wp} - {1'b0, d};
    if (wp < d) begin
      diff = diff + (PTR_W + 1)'(DEPTH);
    end
    return diff[PTR_W-1:0];
  endfunction

  cma_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_line (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (cur.wp),
    .wdata   (cur.sample),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_comb begin
    w_p = PTR_W'(window_width);
    h_p = PTR_W'(window_width >> 1);
    ram_we = (state == WRITE);
    re_a = (state == WRITE);
    re_b = (state == WRITE) || (state == FLUSH_RD);
    raddr_a = back_idx(cur.wp, w_p);
    raddr_b = (state == FLUSH_RD) ? back_idx(cur.wp, fcnt) : back_idx(cur.wp, h_p);

    // Add the new sample, drop the one leaving the window.
    sum_next = window_sum + {{(SUM_W - SW){cur.sample[SW-1]}}, cur.sample};
    if (cur.sub_old) begin
      sum_next = sum_next - {{(SUM_W - SW){rdata_a[SW-1]}}, rdata_a};
    end
    mag = sum_next[SUM_W-1] ? ('0 - sum_next) : sum_next;
    // Rounded |sum|/W, ties away from zero, is floor((|sum| + h) / W) for odd W.
    num = mag + SUM_W'(h_p);

    trial = {rem, dq[QW-1]};
    fits = (trial >= {1'b0, window_width});
    mean = neg ? ('0 - dq) : dq;

    out_free = !out_valid || result_chan.ready;
    out_load = out_free && ((state == PASS) || (state == EMIT_MEAN)
                            || (state == EMIT_LINE) || (state == FLUSH_OUT));
    pop = (state == IDLE) && avail;

    result_chan.valid = out_valid;
    result_chan.sample_out = out_sample;
    result_chan.end_of_record = out_eor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      window_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_chan.ready) begin
        out_valid <= 1'b0;
      end
      if (clear) begin
        window_sum <= '0;
      end else if (state == SUM) begin
        window_sum <= sum_next;
      end else if (out_load && (state == FLUSH_OUT) && (fcnt == '0)) begin
        window_sum <= '0;
      end
      case (state)
        IDLE: begin
          if (avail) begin
            cur <= head;
            state <= head.bypass ? PASS : WRITE;
          end
        end
        PASS: begin
          if (out_free) begin
            out_sample <= cur.sample;
            out_eor <= cur.last;
            state <= IDLE;
          end
        end
        WRITE: begin
          state <= SUM;
        end
        SUM: begin
          fcnt <= cur.first;
          if (cur.emit_now && cur.emit_mean) begin
            rem <= WW'(num >> QW);
            dq <= num[QW-1:0];
            neg <= sum_next[SUM_W-1];
            dcnt <= CNT_W'(QW - 1);
            state <= DIV;
          end else if (cur.emit_now) begin
            state <= EMIT_LINE;
          end else if (cur.last) begin
            state <= FLUSH_RD;
          end else begin
            state <= IDLE;
          end
        end
        DIV: begin
          // One quotient bit per cycle.
          rem <= fits ? WW'(trial - {1'b0, window_width}) : WW'(trial);
          dq <= {dq[QW-2:0], fits};
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= EMIT_MEAN;
          end
        end
        EMIT_MEAN: begin
          if (out_free) begin
            out_sample <= mean;
            out_eor <= 1'b0;
            state <= cur.last ? FLUSH_RD : IDLE;
          end
        end
        EMIT_LINE: begin
          if (out_free) begin
            out_sample <= rdata_b;
            out_eor <= 1'b0;
            state <= cur.last ? FLUSH_RD : IDLE;
          end
        end
        FLUSH_RD: begin
          state <= FLUSH_OUT;
        end
        FLUSH_OUT: begin
          if (out_free) begin
            out_sample <= rdata_b;
            out_eor <= (fcnt == '0);
            if (fcnt == '0) begin
              state <= IDLE;
            end else begin
              fcnt <= fcnt - 1'b1;
              state <= FLUSH_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/cma_checker.sv =====
// Port-level checks for centered_moving_average, attached with bind.
// Depends on cma_pkg.
module cma_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_wen,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cma_pkg::SAMPLE_W-1:0] out_sample,
  input logic                         out_eor
);

  logic       in_acc;
  logic       out_acc;
  logic [8:0] inflight;
  logic [3:0] records;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Every accepted sample leaves exactly once; a window write drops held ones.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      inflight <= '0;
      records <= '0;
    end else begin
      inflight <= inflight + 9'(in_acc) - 9'(out_acc);
      records <= records + 4'(in_acc && in_last) - 4'(out_acc && out_eor);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_eor))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> inflight != '0)
    else $error("result delivered with no sample outstanding");

  a_eor_matches: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_eor |-> records != '0)
    else $error("end of record with no open record ending");

endmodule

bind centered_moving_average cma_checker u_cma_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_wen    (cfg_wen),
  .in_valid   (sample_chan.valid),
  .in_ready   (sample_chan.ready),
  .in_last    (sample_chan.is_last),
  .out_valid  (result_chan.valid),
  .out_ready  (result_chan.ready),
  .out_sample (result_chan.sample_out),
  .out_eor    (result_chan.end_of_record)
);
